// ===== rtl/bcm_pkg.sv =====
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types and constants of the binary code modulation led cube scanner.
// ----------------------------------------------------------------------------
package bcm_pkg;

    localparam int CUBE_EDGE  = 8;
    localparam int COLOR_BITS = 8;

    localparam int COORD_W    = $clog2(CUBE_EDGE);
    localparam int CELLS      = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE;
    localparam int CELL_AW    = $clog2(CELLS);
    localparam int SCAN_ITEMS = CUBE_EDGE * CUBE_EDGE;
    localparam int SCAN_W     = $clog2(SCAN_ITEMS);

    localparam logic [7:0] COLOR_MASK = 8'((1 << COLOR_BITS) - 1);

    // register map (index of the register, decoded from paddr[2])
    localparam logic REG_TOP_BIT_PLANE = 1'b0;
    localparam logic [2:0] TOP_BIT_PLANE_RESET = 3'd3;

    // input kinds carried in s_tuser
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [2:0] pix_x;
        logic [2:0] pix_y;
        logic [2:0] pix_z;
        logic [7:0] red_value;
        logic [7:0] green_value;
        logic [7:0] blue_value;
    } pixel_req_t;

    typedef struct packed {
        logic       red_bit;
        logic       green_bit;
        logic       blue_bit;
        logic [2:0] active_layer;
        logic       latch_last;
    } scan_item_t;

endpackage

// ===== rtl/bcm_scan_core.sv =====
// ----------------------------------------------------------------------------
// bcm_scan_core
// Frame store with clearing pass, pixel writes, bcm tick bookkeeping and the
// serpentine read-out of one layer, one frame store read per cycle when issue_ok.
// ----------------------------------------------------------------------------
module bcm_scan_core
    import bcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] top_bit_plane,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_mode,
    input  pixel_req_t in_pixel,
    input  logic       issue_ok,
    output logic       item_valid,
    output scan_item_t item
);

    pixel_t               frame_mem [CELLS];

    scan_state_t          state_reg, state_next;
    logic [CELL_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SCAN_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [COORD_W-1:0]   layer_reg, layer_next;
    logic [3:0]           plane_reg, plane_next;
    logic [8:0]           tick_reg, tick_next;
    logic [8:0]           period_reg, period_next;
    logic [2:0]           shown_plane_reg, shown_plane_next;

    pixel_t               rd_data_reg;
    logic                 rd_valid_reg;
    logic [2:0]           rd_plane_reg;
    logic [COORD_W-1:0]   rd_layer_reg;
    logic                 rd_last_reg;

    logic                 mem_we;
    logic [CELL_AW-1:0]   mem_waddr;
    pixel_t               mem_wdata;
    logic                 mem_re;
    logic [CELL_AW-1:0]   mem_raddr;

    logic                 accept;
    logic                 pix_in_cube;
    logic [CELL_AW-1:0]   pix_addr;
    logic                 scan_last;
    logic [COORD_W-1:0]   row, col, y_coord, x_coord, xs_coord;

    // tick bookkeeping intermediates
    logic                 wrap;
    logic [COORD_W-1:0]   layer_w;
    logic [3:0]           plane_w;
    logic [8:0]           tick_w, period_w;

    assign accept      = in_valid && in_ready;
    assign pix_in_cube = (int'(in_pixel.pix_x) < CUBE_EDGE) && (int'(in_pixel.pix_y) < CUBE_EDGE)
                         && (int'(in_pixel.pix_z) < CUBE_EDGE);
    assign pix_addr    = CELL_AW'(int'(in_pixel.pix_z) * CUBE_EDGE * CUBE_EDGE
                         + int'(in_pixel.pix_y) * CUBE_EDGE + int'(in_pixel.pix_x));

    // serpentine walk: y and x count down, odd rows mirrored
    assign row       = COORD_W'(scan_cnt_reg / CUBE_EDGE);
    assign col       = COORD_W'(scan_cnt_reg % CUBE_EDGE);
    assign y_coord   = COORD_W'(CUBE_EDGE - 1) - row;
    assign x_coord   = COORD_W'(CUBE_EDGE - 1) - col;
    assign xs_coord  = y_coord[0] ? col : x_coord;
    assign scan_last = (scan_cnt_reg == SCAN_W'(SCAN_ITEMS - 1));
    assign mem_raddr = CELL_AW'(int'(layer_reg) * CUBE_EDGE * CUBE_EDGE
                       + int'(y_coord) * CUBE_EDGE + int'(xs_coord));

    // layer advance happens before the plane is sampled
    always_comb
    begin
        wrap     = plane_reg > {1'b0, top_bit_plane};
        layer_w  = layer_reg;
        plane_w  = plane_reg;
        tick_w   = tick_reg;
        period_w = period_reg;
        if (wrap)
        begin
            layer_w  = (layer_reg == COORD_W'(CUBE_EDGE - 1)) ? '0 : layer_reg + 1'b1;
            plane_w  = '0;
            tick_w   = 9'd1;
            period_w = 9'd1;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        scan_cnt_next    = scan_cnt_reg;
        layer_next       = layer_reg;
        plane_next       = plane_reg;
        tick_next        = tick_reg;
        period_next      = period_reg;
        shown_plane_next = shown_plane_reg;
        in_ready         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = pix_addr;
        mem_wdata.red    = in_pixel.red_value & COLOR_MASK;
        mem_wdata.green  = in_pixel.green_value & COLOR_MASK;
        mem_wdata.blue   = in_pixel.blue_value & COLOR_MASK;
        mem_re           = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CELL_AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && in_mode == MODE_PIXEL)
                begin
                    mem_we = pix_in_cube;
                end
                else if (accept)
                begin
                    layer_next       = layer_w;
                    shown_plane_next = plane_w[2:0];
                    if (tick_w == period_w)
                    begin
                        tick_next   = 9'd1;
                        plane_next  = plane_w + 1'b1;
                        period_next = {period_w[7:0], 1'b0};
                    end
                    else
                    begin
                        tick_next   = tick_w + 1'b1;
                        plane_next  = plane_w;
                        period_next = period_w;
                    end
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // writes happen only in clear and idle, so a read never meets a write
                if (issue_ok)
                begin
                    mem_re        = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    if (scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            scan_cnt_reg    <= '0;
            layer_reg       <= '0;
            plane_reg       <= '0;
            tick_reg        <= 9'd1;
            period_reg      <= 9'd1;
            shown_plane_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            scan_cnt_reg    <= scan_cnt_next;
            layer_reg       <= layer_next;
            plane_reg       <= plane_next;
            tick_reg        <= tick_next;
            period_reg      <= period_next;
            shown_plane_reg <= shown_plane_next;
            rd_valid_reg    <= mem_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg  <= frame_mem[mem_raddr];
            rd_plane_reg <= shown_plane_reg;
            rd_layer_reg <= layer_reg;
            rd_last_reg  <= scan_last;
        end
    end

    assign item_valid        = rd_valid_reg;
    assign item.red_bit      = rd_data_reg.red[rd_plane_reg];
    assign item.green_bit    = rd_data_reg.green[rd_plane_reg];
    assign item.blue_bit     = rd_data_reg.blue[rd_plane_reg];
    assign item.active_layer = 3'(rd_layer_reg);
    assign item.latch_last   = rd_last_reg;

    a_no_write_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("frame store written during a scan");

    a_last_ends_scan : assert property (@(posedge clk) disable iff (!rst_n)
        (mem_re && scan_last) |=> (state_reg == ST_IDLE))
        else $error("scan did not end after the last read");

    a_period_pow2 : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(period_reg))
        else $error("plane period is not a power of two");

    a_tick_in_period : assert property (@(posedge clk) disable iff (!rst_n)
        (period_reg != '0) |-> (tick_reg <= period_reg))
        else $error("tick count ran past the plane period");

endmodule

// ===== rtl/bcm_led_cube_layer_scanner.sv =====
// ----------------------------------------------------------------------------
// bcm_led_cube_layer_scanner
// Binary code modulation driver for an 8x8x8 rgb led cube: pixel writes into
// a frame store, and per display tick one serpentine layer of shift bits.
//
// channel   dir  handshake                fields
// s_*       in   s_tvalid / s_tready      tdata: pixel coords and color, tuser: mode
// m_*       out  m_tvalid / m_tready      tdata: color bits and layer, tlast: latch
// apb       in   psel & penable & pwrite  top_bit_plane at byte address 0
//
// a tick makes one frame store read per shifted bit, 64 in all, through the single
// read port. a shift transfer is offered from the output buffer once its read has
// passed the read register and been written into the buffer.
// after reset a clearing pass zeroes all 512 frame store entries, one per
// cycle; s_tready stays low during the pass, register writes still work.
// a two-entry output buffer keeps reads flowing; a stalled m_tready pauses the
// scan and s_tready stays low until the last read of the tick has been issued.
// ----------------------------------------------------------------------------
module bcm_led_cube_layer_scanner
    import bcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // pix_x[2:0], pix_y[5:3], pix_z[8:6], red_value[16:9],
                                  // green_value[24:17], blue_value[32:25], zero[39:33]
    input  logic        s_tuser,  // mode[0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // red_bit[0], green_bit[1], blue_bit[2],
                                  // active_layer[5:3], zero[7:6]
    output logic        m_tlast   // latch_last
);

    logic [2:0]  top_bit_plane_reg;
    pixel_req_t  in_pixel;
    logic        issue_ok;
    logic        item_valid;
    scan_item_t  item;

    scan_item_t  buf_mem [2];
    logic        buf_wr_ptr_reg, buf_rd_ptr_reg;
    logic [1:0]  buf_cnt_reg, buf_cnt_next;
    logic        push, pop;
    logic [1:0]  buf_load;
    scan_item_t  head;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOP_BIT_PLANE) ? {29'd0, top_bit_plane_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_bit_plane_reg <= TOP_BIT_PLANE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_TOP_BIT_PLANE)
        begin
            top_bit_plane_reg <= pwdata[2:0];
        end
    end

    assign in_pixel.pix_x       = s_tdata[2:0];
    assign in_pixel.pix_y       = s_tdata[5:3];
    assign in_pixel.pix_z       = s_tdata[8:6];
    assign in_pixel.red_value   = s_tdata[16:9];
    assign in_pixel.green_value = s_tdata[24:17];
    assign in_pixel.blue_value  = s_tdata[32:25];

    bcm_scan_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .top_bit_plane (top_bit_plane_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_mode       (s_tuser),
        .in_pixel      (in_pixel),
        .issue_ok      (issue_ok),
        .item_valid    (item_valid),
        .item          (item)
    );

    // output buffer: entries held plus the read in flight never exceed two
    assign push     = item_valid;
    assign pop      = m_tvalid && m_tready;
    assign buf_load = buf_cnt_reg + {1'b0, item_valid};
    assign issue_ok = (buf_load <= 2'd1) || (buf_load == 2'd2 && pop);

    always_comb
    begin
        buf_cnt_next = buf_cnt_reg;
        unique case ({push, pop})
            2'b10:   buf_cnt_next = buf_cnt_reg + 1'b1;
            2'b01:   buf_cnt_next = buf_cnt_reg - 1'b1;
            default: buf_cnt_next = buf_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_wr_ptr_reg <= 1'b0;
            buf_rd_ptr_reg <= 1'b0;
            buf_cnt_reg    <= '0;
        end
        else
        begin
            buf_cnt_reg <= buf_cnt_next;
            if (push)
            begin
                buf_wr_ptr_reg <= ~buf_wr_ptr_reg;
            end
            if (pop)
            begin
                buf_rd_ptr_reg <= ~buf_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[buf_wr_ptr_reg] <= item;
        end
    end

    assign head     = buf_mem[buf_rd_ptr_reg];
    assign m_tvalid = (buf_cnt_reg != 2'd0);
    assign m_tdata  = {2'b00, head.active_layer, head.blue_bit, head.green_bit, head.red_bit};
    assign m_tlast  = head.latch_last;

    a_buf_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        (buf_cnt_reg + {1'b0, item_valid}) <= 2'd2)
        else $error("output buffer overflow");

    a_buf_ptrs : assert property (@(posedge clk) disable iff (!rst_n)
        (buf_cnt_reg == 2'd0 || buf_cnt_reg == 2'd2) |-> (buf_wr_ptr_reg == buf_rd_ptr_reg))
        else $error("output buffer pointers disagree with count");

endmodule
